/* src/hvd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hvd_pkg;

   // Q60 datapath word
   typedef logic signed [63:0] q60_type;

   localparam int MUL_LAT = 3;   // register stages in hvd_mul
   localparam int SQA_W   = 61;  // root width for sqrt(a) and sqrt(1-a)
   localparam int SQH_W   = 52;  // root width for the final hypotenuse

   localparam logic [63:0]  EARTH_RADIUS_MM = 64'd6371000000;
   localparam logic [34:0]  DIST_MAX        = 35'd20100000000;
   localparam logic [63:0]  ONE_Q60         = 64'h1000_0000_0000_0000;
   localparam logic [127:0] DEG_UNITS_HALF  = 128'd1800000000;
   localparam logic [127:0] ONE_WIDE        = 128'd1;

   // restoring long division, elaboration only
   function automatic logic [127:0] udiv128(input logic [127:0] num, input logic [127:0] den);
      logic [127:0] rem;
      logic [127:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 127; i >= 0; i--) begin
         rem = {rem[126:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // floor square root of a 128-bit value, elaboration only
   function automatic logic [63:0] isqrt_const(input logic [127:0] val);
      logic [127:0] res;
      logic [127:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (ONE_WIDE << b);
         if (cand * cand <= val) res = cand;
      end
      return res[63:0];
   endfunction

   // atan(1/m) in Q62 by series
   function automatic logic [127:0] atan_recip_q62(input logic [127:0] m);
      logic [127:0] p;
      logic [127:0] t;
      logic [127:0] sum;
      p   = udiv128(ONE_WIDE << 62, m);
      sum = '0;
      for (int k = 0; k < 40; k++) begin
         if (p != 0) begin
            t = udiv128(p, 128'(2 * k + 1));
            if ((k & 1) != 0) sum = sum - t;
            else sum = sum + t;
            p = udiv128(p, m * m);
         end
      end
      return sum;
   endfunction

   // pi/4 in Q62, which is pi in Q60
   function automatic logic [63:0] calc_pi4_q62();
      logic [127:0] v;
      v = (atan_recip_q62(128'd5) << 2) - atan_recip_q62(128'd239);
      return v[63:0];
   endfunction

   // atan(2^-i) in Q62 for i >= 1
   function automatic logic [127:0] atan_pow2_q62(input int i);
      logic [127:0] sum;
      logic [127:0] t;
      int sh;
      sum = '0;
      for (int k = 0; k < 32; k++) begin
         sh = i * (2 * k + 1);
         if (sh < 63) begin
            t = udiv128((ONE_WIDE << 62) >> sh, 128'(2 * k + 1));
            if ((k & 1) != 0) sum = sum - t;
            else sum = sum + t;
         end
      end
      return sum;
   endfunction

   // CORDIC angle table entry, Q60
   function automatic logic [63:0] atan_q60(input int i);
      logic [127:0] v;
      if (i == 0) v = ({64'd0, calc_pi4_q62()} + 128'd2) >> 2;
      else v = (atan_pow2_q62(i) + 128'd2) >> 2;
      return v[63:0];
   endfunction

   // inverse CORDIC gain for a given step count, Q60
   function automatic logic [63:0] calc_kinv(input int steps);
      logic [127:0] p;
      logic [127:0] inv;
      p = ONE_WIDE << 60;
      for (int i = 0; i < 48; i++) begin
         if (i < steps && 2 * i < 64) p = p + (p >> (2 * i));
      end
      inv = udiv128(ONE_WIDE << 120, p);
      return isqrt_const(inv << 60);
   endfunction

   localparam logic [63:0] PI_Q60 = calc_pi4_q62();

   // pi / 1.8e9 scaled by 2^92, rounded
   function automatic logic [63:0] calc_deg_k92();
      logic [127:0] n;
      logic [127:0] q;
      logic [127:0] r;
      n = {64'd0, PI_Q60} << 32;
      q = udiv128(n, DEG_UNITS_HALF);
      r = n - q * DEG_UNITS_HALF;
      if ((r << 1) >= DEG_UNITS_HALF) q = q + 128'd1;
      return q[63:0];
   endfunction

   localparam logic [63:0] DEG_K92 = calc_deg_k92();

endpackage

`default_nettype wire

/* src/hvd_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sign-magnitude 64x64 multiply from four 32x32 partial products,
// rounded to nearest (ties away from zero) and shifted right by SHIFT.
module hvd_mul
   import hvd_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic         clock,
   input  logic         en,
   input  q60_type      a_i,
   input  q60_type      b_i,
   output logic [127:0] mag_o,
   output logic         neg_o
);

   localparam logic [127:0] RND = (ONE_WIDE << SHIFT) >> 1;

   logic [63:0]  ma_ff, mb_ff;
   logic         n1_ff, n2_ff, n3_ff;
   logic [63:0]  pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [127:0] sum;
   logic [127:0] mag_ff;

   // stage 1: magnitudes
   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= a_i[63] ? 64'(-a_i) : 64'(a_i);
         mb_ff <= b_i[63] ? 64'(-b_i) : 64'(b_i);
         n1_ff <= a_i[63] ^ b_i[63];
      end
   end

   // stage 2: partial products
   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= ma_ff[31:0]  * mb_ff[31:0];
         pp01_ff <= ma_ff[31:0]  * mb_ff[63:32];
         pp10_ff <= ma_ff[63:32] * mb_ff[31:0];
         pp11_ff <= ma_ff[63:32] * mb_ff[63:32];
         n2_ff   <= n1_ff;
      end
   end

   // stage 3: sum, round, shift
   assign sum = {64'd0, pp00_ff} + {32'd0, pp01_ff, 32'd0} + {32'd0, pp10_ff, 32'd0}
              + {pp11_ff, 64'd0} + RND;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= sum >> SHIFT;
         n3_ff  <= n2_ff;
      end
   end

   assign mag_o = mag_ff;
   assign neg_o = n3_ff;

endmodule

`default_nettype wire

/* src/hvd_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

// Unrolled CORDIC, one iteration per stage. Rotation mode folds the angle
// into [-pi/2, pi/2] first and negates the cosine of a folded angle; vectoring drives y to 0.
module hvd_cordic
   import hvd_pkg::*;
#(
   parameter int STEPS  = 32,
   parameter bit VECTOR = 1'b0
) (
   input  logic    clock,
   input  logic    en,
   input  q60_type x_i,
   input  q60_type y_i,
   input  q60_type z_i,
   output q60_type x_o,
   output q60_type y_o,
   output q60_type z_o
);

   localparam q60_type PI   = q60_type'(PI_Q60);
   localparam q60_type HALF = q60_type'(PI_Q60 / 2);

   q60_type xs_ff [STEPS+1];
   q60_type ys_ff [STEPS+1];
   q60_type zs_ff [STEPS+1];
   logic    fs_ff [STEPS+1];

   q60_type z_fold;
   logic    flip;

   // angle fold
   always_comb begin
      z_fold = z_i;
      flip   = 1'b0;
      if (!VECTOR && z_i > HALF) begin
         z_fold = PI - z_i;
         flip   = 1'b1;
      end else if (!VECTOR && z_i < -HALF) begin
         z_fold = -PI - z_i;
         flip   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xs_ff[0] <= x_i;
         ys_ff[0] <= y_i;
         zs_ff[0] <= z_fold;
         fs_ff[0] <= flip;
      end
   end

   // iterations
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam q60_type ATAN = q60_type'(atan_q60(k));
      q60_type dx, dy;
      logic    up;
      assign dx = ys_ff[k] >>> k;
      assign dy = xs_ff[k] >>> k;
      assign up = VECTOR ? ys_ff[k][63] : !zs_ff[k][63];

      always_ff @(posedge clock) begin
         if (en) begin
            fs_ff[k+1] <= fs_ff[k];
            if (up) begin
               xs_ff[k+1] <= xs_ff[k] - dx;
               ys_ff[k+1] <= ys_ff[k] + dy;
               zs_ff[k+1] <= zs_ff[k] - ATAN;
            end else begin
               xs_ff[k+1] <= xs_ff[k] + dx;
               ys_ff[k+1] <= ys_ff[k] - dy;
               zs_ff[k+1] <= zs_ff[k] + ATAN;
            end
         end
      end
   end

   assign x_o = fs_ff[STEPS] ? -xs_ff[STEPS] : xs_ff[STEPS];
   assign y_o = ys_ff[STEPS];
   assign z_o = zs_ff[STEPS];

endmodule

`default_nettype wire

/* src/hvd_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Floor square root, one result bit per stage (digit recurrence).
module hvd_isqrt #(
   parameter int RES_W = 52
) (
   input  logic               clock,
   input  logic               en,
   input  logic [2*RES_W-1:0] rad_i,
   output logic [RES_W-1:0]   root_o
);

   localparam int REM_W = RES_W + 3;

   logic [REM_W-1:0]   rem_ff  [RES_W];
   logic [RES_W-1:0]   root_ff [RES_W];
   logic [2*RES_W-1:0] rad_ff  [RES_W];

   for (genvar k = 0; k < RES_W; k++) begin : g_digit
      logic [REM_W-1:0]   rem_prev, rem_sh, trial;
      logic [RES_W-1:0]   root_prev;
      logic [2*RES_W-1:0] rad_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // bring down two radicand bits, try (4*root + 1)
      assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[2*RES_W-1 -: 2]};
      assign trial  = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k] <= {rad_prev[2*RES_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_prev[RES_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_prev[RES_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root_o = root_ff[RES_W-1];

endmodule

`default_nettype wire

/* src/haversine_distance_3d.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Depth is set by the two unrolled CORDIC chains and the two bit-per-stage square roots.
// Reset (synchronous, active high) clears the stage valid bits only; data is not reset.
module haversine_distance_3d
   import hvd_pkg::*;
#(
   parameter int CORDIC_STEPS        = 32,
   parameter int ANGLE_FRACTION_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_latitude[30:0], first_longitude[62:31], first_altitude[87:63],
   // second_latitude[118:88], second_longitude[150:119], second_altitude[175:151]
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance_mm[34:0], zero fill above
   output logic [39:0]  rsp_tdata
);

   localparam q60_type KINV      = q60_type'(calc_kinv(CORDIC_STEPS));
   localparam q60_type DEG_K     = q60_type'(DEG_K92);
   localparam q60_type RADIUS    = q60_type'(EARTH_RADIUS_MM);
   localparam q60_type ONE       = q60_type'(ONE_Q60);
   localparam int      RAD_SHIFT = 92 - ANGLE_FRACTION_BITS;
   localparam int      HALF_UP   = 59 - ANGLE_FRACTION_BITS;
   localparam int      FULL_UP   = 60 - ANGLE_FRACTION_BITS;
   localparam int      ALT_DLY   = 4 * MUL_LAT + 2 * CORDIC_STEPS + SQA_W + 4;
   localparam int      TOTAL_LAT = ALT_DLY + MUL_LAT + SQH_W + 2;

   logic en;
   logic [TOTAL_LAT-1:0] vld_ff;

   // global advance: move when the output slot is free or being taken
   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   // input fields
   logic signed [30:0] lat1, lat2;
   logic signed [31:0] lon1, lon2;
   logic signed [24:0] alt1, alt2;
   assign lat1 = req_tdata[30:0];
   assign lon1 = req_tdata[62:31];
   assign alt1 = req_tdata[87:63];
   assign lat2 = req_tdata[118:88];
   assign lon2 = req_tdata[150:119];
   assign alt2 = req_tdata[175:151];

   // degrees to radians
   logic [127:0] m_lat1, m_lon1, m_lat2, m_lon2;
   logic         n_lat1, n_lon1, n_lat2, n_lon2;

   hvd_mul #(.SHIFT(RAD_SHIFT)) u_rad_lat1 (.clock, .en, .a_i({{33{lat1[30]}}, lat1}),
      .b_i(DEG_K), .mag_o(m_lat1), .neg_o(n_lat1));
   hvd_mul #(.SHIFT(RAD_SHIFT)) u_rad_lon1 (.clock, .en, .a_i({{32{lon1[31]}}, lon1}),
      .b_i(DEG_K), .mag_o(m_lon1), .neg_o(n_lon1));
   hvd_mul #(.SHIFT(RAD_SHIFT)) u_rad_lat2 (.clock, .en, .a_i({{33{lat2[30]}}, lat2}),
      .b_i(DEG_K), .mag_o(m_lat2), .neg_o(n_lat2));
   hvd_mul #(.SHIFT(RAD_SHIFT)) u_rad_lon2 (.clock, .en, .a_i({{32{lon2[31]}}, lon2}),
      .b_i(DEG_K), .mag_o(m_lon2), .neg_o(n_lon2));

   q60_type r_lat1, r_lon1, r_lat2, r_lon2;
   assign r_lat1 = n_lat1 ? -q60_type'(m_lat1[63:0]) : q60_type'(m_lat1[63:0]);
   assign r_lon1 = n_lon1 ? -q60_type'(m_lon1[63:0]) : q60_type'(m_lon1[63:0]);
   assign r_lat2 = n_lat2 ? -q60_type'(m_lat2[63:0]) : q60_type'(m_lat2[63:0]);
   assign r_lon2 = n_lon2 ? -q60_type'(m_lon2[63:0]) : q60_type'(m_lon2[63:0]);

   // rotation angles in Q60
   q60_type th_dl_in, th_dn_in, th_1_in, th_2_in;
   q60_type th_dl_ff, th_dn_ff, th_1_ff, th_2_ff;
   assign th_dl_in = (r_lat2 - r_lat1) <<< HALF_UP;
   assign th_dn_in = (r_lon2 - r_lon1) <<< HALF_UP;
   assign th_1_in  = r_lat1 <<< FULL_UP;
   assign th_2_in  = r_lat2 <<< FULL_UP;

   always_ff @(posedge clock) begin
      if (en) begin
         th_dl_ff <= th_dl_in;
         th_dn_ff <= th_dn_in;
         th_1_ff  <= th_1_in;
         th_2_ff  <= th_2_in;
      end
   end

   // sine and cosine
   q60_type sdl, sdn, c1, c2;

   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_dl (.clock, .en, .x_i(KINV),
      .y_i('0), .z_i(th_dl_ff), .x_o(), .y_o(sdl), .z_o());
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_dn (.clock, .en, .x_i(KINV),
      .y_i('0), .z_i(th_dn_ff), .x_o(), .y_o(sdn), .z_o());
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_l1 (.clock, .en, .x_i(KINV),
      .y_i('0), .z_i(th_1_ff), .x_o(c1), .y_o(), .z_o());
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_l2 (.clock, .en, .x_i(KINV),
      .y_i('0), .z_i(th_2_ff), .x_o(c2), .y_o(), .z_o());

   // haversine products
   logic [127:0] m_cc, m_nn, m_ll, m_t;
   logic         n_cc, n_nn, n_ll, n_t;

   hvd_mul #(.SHIFT(60)) u_mul_cc (.clock, .en, .a_i(c1), .b_i(c2),
      .mag_o(m_cc), .neg_o(n_cc));
   hvd_mul #(.SHIFT(60)) u_mul_nn (.clock, .en, .a_i(sdn), .b_i(sdn),
      .mag_o(m_nn), .neg_o(n_nn));
   hvd_mul #(.SHIFT(60)) u_mul_ll (.clock, .en, .a_i(sdl), .b_i(sdl),
      .mag_o(m_ll), .neg_o(n_ll));

   q60_type p_cc, p_nn, p_ll, p_t;
   assign p_cc = n_cc ? -q60_type'(m_cc[63:0]) : q60_type'(m_cc[63:0]);
   assign p_nn = n_nn ? -q60_type'(m_nn[63:0]) : q60_type'(m_nn[63:0]);
   assign p_ll = n_ll ? -q60_type'(m_ll[63:0]) : q60_type'(m_ll[63:0]);

   hvd_mul #(.SHIFT(60)) u_mul_t (.clock, .en, .a_i(p_cc), .b_i(p_nn),
      .mag_o(m_t), .neg_o(n_t));
   assign p_t = n_t ? -q60_type'(m_t[63:0]) : q60_type'(m_t[63:0]);

   // align sin^2(dlat/2) with the second product
   q60_type ll_dly_ff [MUL_LAT];
   always_ff @(posedge clock) begin
      if (en) begin
         ll_dly_ff[0] <= p_ll;
         for (int i = 1; i < MUL_LAT; i++) ll_dly_ff[i] <= ll_dly_ff[i-1];
      end
   end

   // a, clamped to [0, 1]
   q60_type a_sum, a_in;
   logic [60:0] a_ff;
   logic [60:0] b_rest;
   assign a_sum = ll_dly_ff[MUL_LAT-1] + p_t;

   always_comb begin
      a_in = a_sum;
      if (a_sum < 0) a_in = '0;
      else if (a_sum > ONE) a_in = ONE;
   end

   always_ff @(posedge clock) begin
      if (en) a_ff <= a_in[60:0];
   end

   assign b_rest = ONE_Q60[60:0] - a_ff;

   // sqrt(a), sqrt(1 - a)
   logic [SQA_W-1:0] sa, sb;

   hvd_isqrt #(.RES_W(SQA_W)) u_sqrt_a (.clock, .en,
      .rad_i({1'b0, a_ff, 60'd0}), .root_o(sa));
   hvd_isqrt #(.RES_W(SQA_W)) u_sqrt_b (.clock, .en,
      .rad_i({1'b0, b_rest, 60'd0}), .root_o(sb));

   // central half angle
   q60_type zc;
   hvd_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (.clock, .en,
      .x_i(q60_type'({3'd0, sb})), .y_i(q60_type'({3'd0, sa})), .z_i('0),
      .x_o(), .y_o(), .z_o(zc));

   // great-circle length, millimetres with 16 fraction bits
   q60_type twice_z;
   logic [127:0] m_d;
   logic         n_d;
   q60_type      d_val;
   assign twice_z = zc[63] ? '0 : {zc[62:0], 1'b0};

   hvd_mul #(.SHIFT(44)) u_mul_d (.clock, .en, .a_i(twice_z), .b_i(RADIUS),
      .mag_o(m_d), .neg_o(n_d));
   assign d_val = n_d ? -q60_type'(m_d[63:0]) : q60_type'(m_d[63:0]);

   // altitude difference, delayed to meet d
   logic signed [25:0] alt_diff;
   logic signed [25:0] alt_dly_ff [ALT_DLY];
   logic signed [25:0] alt_last;
   logic        [25:0] alt_mag;
   assign alt_diff = {alt2[24], alt2} - {alt1[24], alt1};

   always_ff @(posedge clock) begin
      if (en) begin
         alt_dly_ff[0] <= alt_diff;
         for (int i = 1; i < ALT_DLY; i++) alt_dly_ff[i] <= alt_dly_ff[i-1];
      end
   end

   assign alt_last = alt_dly_ff[ALT_DLY-1];
   assign alt_mag  = alt_last[25] ? 26'(-alt_last) : 26'(alt_last);

   // squares
   logic [127:0] m_dd, m_hh;
   logic         n_dd, n_hh;

   hvd_mul #(.SHIFT(0)) u_mul_dd (.clock, .en, .a_i(d_val), .b_i(d_val),
      .mag_o(m_dd), .neg_o(n_dd));
   hvd_mul #(.SHIFT(0)) u_mul_hh (.clock, .en,
      .a_i(q60_type'({22'd0, alt_mag, 16'd0})), .b_i(q60_type'({22'd0, alt_mag, 16'd0})),
      .mag_o(m_hh), .neg_o(n_hh));

   // squares are never negative; flags kept only to close the product units
   logic [127:0] hyp_sum;
   logic [2*SQH_W-1:0] hyp_ff;
   assign hyp_sum = (n_dd & n_hh) ? '0 : m_dd + m_hh;

   always_ff @(posedge clock) begin
      if (en) hyp_ff <= hyp_sum[2*SQH_W-1:0];
   end

   logic [SQH_W-1:0] hyp_root;
   hvd_isqrt #(.RES_W(SQH_W)) u_sqrt_h (.clock, .en, .rad_i(hyp_ff), .root_o(hyp_root));

   // round to millimetres and saturate
   logic [SQH_W:0]   rnd;
   logic [SQH_W-16:0] mm;
   logic [34:0]      dist_in, dist_ff;
   assign rnd = {1'b0, hyp_root} + (SQH_W+1)'(32768);
   assign mm  = rnd[SQH_W:16];

   always_comb begin
      if (mm > (SQH_W-15)'(DIST_MAX)) dist_in = DIST_MAX;
      else dist_in = mm[34:0];
   end

   always_ff @(posedge clock) begin
      if (en) dist_ff <= dist_in;
   end

   assign rsp_tdata = {5'd0, dist_ff};

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import hvd_pkg::*;

   localparam int STEPS      = 32;
   localparam int FRAC       = 32;
   localparam int LATENCY    = 2 * STEPS + 134;
   localparam int CYCLE_CAP  = 400000;
   localparam int RANDOM_CNT = 1700;
   localparam int CALM_TAIL  = 150;

   typedef struct {
      logic signed [30:0] lat1;
      logic signed [31:0] lon1;
      logic signed [24:0] alt1;
      logic signed [30:0] lat2;
      logic signed [31:0] lon2;
      logic signed [24:0] alt2;
   } point_pair_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   point_pair_type    pair_queue[$];
   logic [34:0]       distance_expected[$];
   longint            arc_step[STEPS];
   longint            pi_fix;
   longint            gain_inv;
   longint            deg_to_rad;
   int                fail_count;
   int                cycle_count;
   int                req_gap;
   int                rsp_stall;
   bit                req_fired;

   haversine_distance_3d DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------- fixed-point helpers ----------------
   function automatic logic [63:0] magnitude(longint v);
      logic [63:0] u;
      u = v;
      return (v < 0) ? ~u + 64'd1 : u;
   endfunction

   // round(a*b / 2^s), ties away from zero, saturating
   function automatic longint round_product(longint a, longint b, int s);
      logic         neg;
      logic [127:0] p;
      logic [63:0]  r;
      neg = (a < 0) != (b < 0);
      p = 128'(magnitude(a)) * 128'(magnitude(b));
      p = (p + (128'd1 << (s - 1))) >> s;
      r = p[63:0];
      if (r > 64'h7fff_ffff_ffff_ffff) r = 64'h7fff_ffff_ffff_ffff;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [63:0] floor_root(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (128'(c) * 128'(c) <= v) r = c;
      end
      return r;
   endfunction

   // atan(1/m) in Q62
   function automatic longint atan_recip(logic [63:0] m);
      logic [63:0] p;
      logic [63:0] k;
      longint      sum;
      longint      t;
      p = (64'd1 << 62) / m;
      sum = 0;
      k = 0;
      while (p != 0) begin
         t = longint'(p / (2 * k + 1));
         sum = k[0] ? sum - t : sum + t;
         p = p / (m * m);
         k++;
      end
      return sum;
   endfunction

   // atan(2^-i) in Q62
   function automatic longint atan_pow2(int i);
      longint sum;
      longint t;
      int     k;
      int     sh;
      sum = 0;
      k = 0;
      sh = i;
      while (sh < 63) begin
         t = longint'(((64'd1 << 62) >> sh) / (2 * k + 1));
         sum = k[0] ? sum - t : sum + t;
         k++;
         sh = i * (2 * k + 1);
      end
      return sum;
   endfunction

   function automatic void build_constants();
      longint       pi4;
      logic [63:0]  p;
      logic [127:0] inv;
      logic [127:0] n;
      logic [127:0] q;
      logic [127:0] r;
      pi4 = 4 * atan_recip(5) - atan_recip(239);
      pi_fix = pi4;
      arc_step[0] = (pi4 + 2) >>> 2;
      for (int i = 1; i < STEPS; i++) arc_step[i] = (atan_pow2(i) + 2) >>> 2;
      p = 64'd1 << 60;
      for (int i = 0; i < STEPS; i++) if (2 * i < 64) p = p + (p >> (2 * i));
      inv = (128'd1 << 120) / 128'(p);
      gain_inv = longint'(floor_root(inv << 60));
      n = 128'(pi_fix) << 32;
      q = n / 128'd1800000000;
      r = n % 128'd1800000000;
      if (2 * r >= 128'd1800000000) q = q + 1;
      deg_to_rad = longint'(q[63:0]);
   endfunction

   // rotation mode, angle folded into [-pi/2, pi/2]
   function automatic void rotate_angle(longint th, output longint s, output longint c);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      logic   flip;
      x = gain_inv;
      y = 0;
      flip = 1'b0;
      if (th > pi_fix / 2) begin
         th = pi_fix - th;
         flip = 1'b1;
      end else if (th < -(pi_fix / 2)) begin
         th = -pi_fix - th;
         flip = 1'b1;
      end
      z = th;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arc_step[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arc_step[i];
         end
      end
      s = y;
      c = flip ? -x : x;
   endfunction

   // vectoring mode, first quadrant
   function automatic longint vector_angle(longint y, longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + arc_step[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - arc_step[i];
         end
      end
      return z;
   endfunction

   function automatic longint to_radians(longint units);
      return round_product(units, deg_to_rad, 92 - FRAC);
   endfunction

   function automatic logic [34:0] predict_distance(point_pair_type pp);
      longint       lat1, lon1, lat2, lon2;
      longint       sdl, cdl, sdn, cdn, s1, c1, s2, c2;
      longint       a, t, z, d;
      logic [63:0]  sa, sb, h, hyp, mm;
      logic [127:0] sq;
      lat1 = to_radians(longint'(pp.lat1));
      lon1 = to_radians(longint'(pp.lon1));
      lat2 = to_radians(longint'(pp.lat2));
      lon2 = to_radians(longint'(pp.lon2));
      rotate_angle((lat2 - lat1) * (64'sd1 <<< (59 - FRAC)), sdl, cdl);
      rotate_angle((lon2 - lon1) * (64'sd1 <<< (59 - FRAC)), sdn, cdn);
      rotate_angle(lat1 * (64'sd1 <<< (60 - FRAC)), s1, c1);
      rotate_angle(lat2 * (64'sd1 <<< (60 - FRAC)), s2, c2);
      t = round_product(round_product(c1, c2, 60), round_product(sdn, sdn, 60), 60);
      a = round_product(sdl, sdl, 60) + t;
      if (a < 0) a = 0;
      if (a > longint'(ONE_Q60)) a = longint'(ONE_Q60);
      sa = floor_root(128'(a) << 60);
      sb = floor_root(128'(longint'(ONE_Q60) - a) << 60);
      z = vector_angle(longint'(sa), longint'(sb));
      if (z < 0) z = 0;
      d = round_product(2 * z, 64'sd6371000000, 44);
      h = magnitude((longint'(pp.alt2) - longint'(pp.alt1)) * 65536);
      sq = 128'(d) * 128'(d) + 128'(h) * 128'(h);
      hyp = floor_root(sq);
      mm = (hyp + 64'd32768) >> 16;
      if (mm > 64'(DIST_MAX)) mm = 64'(DIST_MAX);
      return mm[34:0];
   endfunction

   function automatic point_pair_type make_pair(longint la1, longint lo1, longint al1,
                                                longint la2, longint lo2, longint al2);
      point_pair_type pp;
      pp.lat1 = la1[30:0];
      pp.lon1 = lo1[31:0];
      pp.alt1 = al1[24:0];
      pp.lat2 = la2[30:0];
      pp.lon2 = lo2[31:0];
      pp.alt2 = al2[24:0];
      return pp;
   endfunction

   function automatic longint rand_lat();
      return longint'($urandom_range(0, 1800000000)) - 900000000;
   endfunction

   function automatic longint rand_lon();
      return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
   endfunction

   function automatic longint rand_alt();
      return longint'($urandom_range(0, 9500000)) - 500000;
   endfunction

   // ---------------- stimulus ----------------
   initial begin
      longint la, lo, al;
      point_pair_type pp;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      req_gap    = 0;
      rsp_stall  = 0;
      req_fired  = 1'b0;
      build_constants();

      // directed: identical points, poles, antipodes, dateline, raw extremes
      pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0));
      pair_queue.push_back(make_pair(473977000, 85450000, 408000,
                                     473977000, 85450000, 408000));
      pair_queue.push_back(make_pair(900000000, 0, 0, -900000000, 0, 0));
      pair_queue.push_back(make_pair(0, 0, 0, 0, 1800000000, 0));
      pair_queue.push_back(make_pair(0, -1800000000, 0, 0, 1800000000, 0));
      pair_queue.push_back(make_pair(0, 1799999999, 0, 0, -1799999999, 0));
      pair_queue.push_back(make_pair(0, 0, -500000, 0, 1800000000, 9000000));
      pair_queue.push_back(make_pair(0, 0, -500000, 0, 0, 9000000));
      pair_queue.push_back(make_pair(900000000, 1800000000, 9000000,
                                     900000000, -1800000000, -500000));
      pair_queue.push_back(make_pair(-(64'sd1 <<< 30), -(64'sd1 <<< 31), -(64'sd1 <<< 24),
                                     (64'sd1 <<< 30) - 1, (64'sd1 <<< 31) - 1,
                                     (64'sd1 <<< 24) - 1));
      pair_queue.push_back(make_pair((64'sd1 <<< 30) - 1, (64'sd1 <<< 31) - 1,
                                     (64'sd1 <<< 24) - 1, -(64'sd1 <<< 30),
                                     -(64'sd1 <<< 31), -(64'sd1 <<< 24)));
      pair_queue.push_back(make_pair(1000000000, 0, 0, -1000000000, 0, 0));
      pair_queue.push_back(make_pair(0, 0, 0, 1, 0, 0));
      pair_queue.push_back(make_pair(0, 0, 0, 0, 1, 0));
      pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 1));
      pair_queue.push_back(make_pair(-900000000, 1234567890, 100, -899999999, -1234567890, 0));
      pair_queue.push_back(make_pair(450000000, 900000000, 0, -450000000, -900000000, 0));
      pair_queue.push_back(make_pair(0, 64'sd2147483647, 0, 0, -(64'sd2147483648), 0));

      // random: in-range, nearby pairs, raw bit patterns, repeated points
      for (int n = 0; n < RANDOM_CNT; n++) begin
         case ($urandom_range(0, 9)) inside
            [0:4]: pp = make_pair(rand_lat(), rand_lon(), rand_alt(),
                                  rand_lat(), rand_lon(), rand_alt());
            [5:6]: begin
               la = rand_lat();
               lo = rand_lon();
               al = rand_alt();
               pp = make_pair(la, lo, al,
                              la + longint'($urandom_range(0, 40000)) - 20000,
                              lo + longint'($urandom_range(0, 40000)) - 20000,
                              al + longint'($urandom_range(0, 20000)) - 10000);
            end
            [7:8]: pp = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: begin
               la = rand_lat();
               lo = rand_lon();
               al = rand_alt();
               pp = make_pair(la, lo, al, la, lo,
                              ($urandom_range(0, 1) == 0) ? al : rand_alt());
            end
         endcase
         pair_queue.push_back(pp);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pair_queue.size() == 0 && !req_tvalid);
      wait (distance_expected.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("haversine_distance_3d regression: pass");
      end else begin
         $display("haversine_distance_3d regression: fail");
      end
      $finish;
   end

   // ---------------- driver ----------------
   always @(negedge clock) begin
      logic           nv;
      logic [175:0]   nd;
      point_pair_type pp;
      logic           calm;
      nv = req_tvalid;
      nd = req_tdata;
      calm = pair_queue.size() < CALM_TAIL;
      if (!reset && (!req_tvalid || req_fired)) begin
         nv = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 16);
         end else if (pair_queue.size() > 0) begin
            pp = pair_queue.pop_front();
            nv = 1'b1;
            nd = {pp.alt2, pp.lon2, pp.lat2, pp.alt1, pp.lon1, pp.lat1};
         end
      end
      req_fired = 1'b0;
      req_tvalid <= nv;
      req_tdata  <= nd;

      // result back-pressure
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin
      point_pair_type pp;
      logic [34:0]    want;
      if (!reset && req_tvalid && req_tready) begin
         req_fired = 1'b1;
         {pp.alt2, pp.lon2, pp.lat2, pp.alt1, pp.lon1, pp.lat1} = req_tdata;
         distance_expected.push_back(predict_distance(pp));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (distance_expected.size() == 0) begin
            $error("unexpected transaction: distance_mm actual %0d", rsp_tdata[34:0]);
            fail_count++;
         end else begin
            want = distance_expected.pop_front();
            if (rsp_tdata[34:0] !== want) begin
               $error("distance_mm expected %0d actual %0d", want, rsp_tdata[34:0]);
               fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("haversine_distance_3d regression: fail");
         $finish;
      end
   end

endmodule
